### sv/bis_pkg.sv
// Package with the shared constants, types and codes of the bilinear image scaler.
`default_nettype none
package bis_pkg;

    // Frame store geometry and fixed-point format.
    localparam int MAX_ROWS  = 256;
    localparam int MAX_COLS  = 256;
    localparam int FRAC_BITS = 16;

    localparam int ROW_AW  = $clog2(MAX_ROWS);
    localparam int COL_AW  = $clog2(MAX_COLS);
    localparam int IDX_AW  = (ROW_AW > COL_AW) ? ROW_AW : COL_AW;
    localparam int BANK_AW = (ROW_AW - 1) + (COL_AW - 1);
    localparam int BANK_DEPTH = 1 << BANK_AW;

    // Field widths of the item and result.
    localparam int IDX_W  = 8;
    localparam int CH_W   = 8;
    localparam int NUM_CH = 3;
    localparam int PIX_W  = CH_W * NUM_CH;
    localparam int STEP_W = 26;

    // Datapath widths.
    localparam int PROD_W = IDX_W + STEP_W;
    localparam int INT_W  = PROD_W - FRAC_BITS;
    localparam int WF_W   = FRAC_BITS + 1;
    localparam int W_W    = 2 * FRAC_BITS + 1;
    localparam int MUL_W  = CH_W + W_W;
    localparam int SUM_W  = MUL_W + 2;

    // Configuration port.
    localparam int CFG_IW = 2;
    localparam int CFG_DW = STEP_W;
    localparam logic [CFG_IW-1:0] CFG_MODE     = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_ROW_STEP = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_COL_STEP = 2'd2;
    localparam logic [STEP_W-1:0] STEP_RESET   = STEP_W'(1 << FRAC_BITS);

    // Operation codes.
    localparam logic OP_WRITE   = 1'b0;
    localparam logic OP_COMPUTE = 1'b1;

    // Split position of one axis: base neighbor, next neighbor, fraction.
    typedef struct packed {
        logic [IDX_AW-1:0]    lo;
        logic [IDX_AW-1:0]    hi;
        logic [FRAC_BITS-1:0] frac;
    } t_pos;

    // The four interpolation weights.
    typedef struct packed {
        logic [W_W-1:0] w00;
        logic [W_W-1:0] w10;
        logic [W_W-1:0] w01;
        logic [W_W-1:0] w11;
    } t_weights;

    // One channel of the four neighbors.
    typedef struct packed {
        logic [CH_W-1:0] p00;
        logic [CH_W-1:0] p10;
        logic [CH_W-1:0] p01;
        logic [CH_W-1:0] p11;
    } t_quad;

endpackage
`default_nettype wire

### sv/bis_in_if.sv
// Interface of the input channel carrying write and compute items.
`default_nettype none
interface bis_in_if;
    import bis_pkg::*;
    logic              valid;
    logic              ready;
    logic              operation;
    logic [IDX_W-1:0]  row_index;
    logic [IDX_W-1:0]  col_index;
    logic [CH_W-1:0]   pixel_c0;
    logic [CH_W-1:0]   pixel_c1;
    logic [CH_W-1:0]   pixel_c2;

    modport source (output valid, operation, row_index, col_index,
                    pixel_c0, pixel_c1, pixel_c2, input ready);
    modport sink   (input valid, operation, row_index, col_index,
                    pixel_c0, pixel_c1, pixel_c2, output ready);
endinterface
`default_nettype wire

### sv/bis_out_if.sv
// Interface of the output channel carrying interpolated pixels.
`default_nettype none
interface bis_out_if;
    import bis_pkg::*;
    logic             valid;
    logic             ready;
    logic [CH_W-1:0]  result_c0;
    logic [CH_W-1:0]  result_c1;
    logic [CH_W-1:0]  result_c2;

    modport source (output valid, result_c0, result_c1, result_c2, input ready);
    modport sink   (input valid, result_c0, result_c1, result_c2, output ready);
endinterface
`default_nettype wire

### sv/bis_pos.sv
// Position unit: scales one output coordinate and splits it into neighbors and fraction.
`default_nettype none
module bis_pos (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic [bis_pkg::IDX_W-1:0]     i_idx,
    input  wire logic [bis_pkg::STEP_W-1:0]    i_step,
    input  wire logic [bis_pkg::IDX_AW-1:0]    i_last,
    output bis_pkg::t_pos                      o_pos
);
    import bis_pkg::*;

    logic [PROD_W-1:0] r_prod;
    logic [PROD_W-1:0] n_prod;
    logic [INT_W-1:0]  int_part;
    logic [INT_W-1:0]  last_ext;
    logic [IDX_AW-1:0] lo;

    assign n_prod = PROD_W'(i_idx) * PROD_W'(i_step);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod <= '0;
        end else if (i_en) begin
            r_prod <= n_prod;
        end
    end

    // Both neighbors saturate at the last row or column; the fraction is kept.
    always_comb begin
        int_part = r_prod[PROD_W-1:FRAC_BITS];
        last_ext = INT_W'(i_last);
        lo = (int_part > last_ext) ? i_last : IDX_AW'(int_part);
        o_pos.lo   = lo;
        o_pos.hi   = (lo == i_last) ? lo : lo + IDX_AW'(1);
        o_pos.frac = r_prod[FRAC_BITS-1:0];
    end

    a_lo_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pos.lo <= i_last) else $error("base neighbor beyond the store");
    a_hi_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pos.hi <= i_last) else $error("next neighbor beyond the store");
    a_hi_adjacent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pos.hi == o_pos.lo) || (o_pos.hi == o_pos.lo + IDX_AW'(1)))
        else $error("neighbors are not adjacent");

endmodule
`default_nettype wire

### sv/bis_bank.sv
// One parity bank of the frame store with a registered read port.
`default_nettype none
module bis_bank (
    input  wire logic                         i_clk,
    input  wire logic                         i_en,
    input  wire logic                         i_we,
    input  wire logic [bis_pkg::BANK_AW-1:0]  i_waddr,
    input  wire logic [bis_pkg::PIX_W-1:0]    i_wdata,
    input  wire logic [bis_pkg::BANK_AW-1:0]  i_raddr,
    output logic      [bis_pkg::PIX_W-1:0]    o_rdata
);
    import bis_pkg::*;

    logic [PIX_W-1:0] mem [BANK_DEPTH];
    logic [PIX_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // The read data holds while the pipeline is stalled.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

### sv/bis_lane.sv
// Channel lane: weighted products of the four neighbors, then their truncated sum.
`default_nettype none
module bis_lane (
    input  wire logic                      i_clk,
    input  wire logic                      i_en,
    input  wire bis_pkg::t_quad            i_pix,
    input  wire bis_pkg::t_weights         i_w,
    output logic      [bis_pkg::CH_W-1:0]  o_value
);
    import bis_pkg::*;

    logic [MUL_W-1:0] r_m00, r_m10, r_m01, r_m11;
    logic [SUM_W-1:0] sum;
    logic [CH_W-1:0]  r_value;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m00 <= MUL_W'(i_pix.p00) * MUL_W'(i_w.w00);
            r_m10 <= MUL_W'(i_pix.p10) * MUL_W'(i_w.w10);
            r_m01 <= MUL_W'(i_pix.p01) * MUL_W'(i_w.w01);
            r_m11 <= MUL_W'(i_pix.p11) * MUL_W'(i_w.w11);
        end
    end

    assign sum = SUM_W'(r_m00) + SUM_W'(r_m10) + SUM_W'(r_m01) + SUM_W'(r_m11);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_value <= sum[2*FRAC_BITS +: CH_W];
        end
    end

    assign o_value = r_value;

endmodule
`default_nettype wire

### sv/bilinear_image_scaler_core.sv
// Top level of the bilinear image scaler: frame store, position units, channel lanes, merge.
//
//  Channel   Direction  Transfer condition        Payload
//  i_in      sink       valid && ready            operation, row/col index, three pixels
//  o_out     source     valid && ready            result_c0..result_c2
//  cfg       write      i_cfg_we                  register index, data
//
// One item is taken per clock cycle unless the output stalls. A compute item passes the
// first-stage, bank read, weight, lane product and sum, and output registers; a write item
// gives no result and lands in the frame store after its first-stage register. The whole
// pipeline advances on one enable that is high while the output register is empty or being
// taken, so a stalled output holds every stage in place. Reset clears the valid flags, the
// configuration and position products; the frame store is not cleared, needs no setup pass.
`default_nettype none
module bilinear_image_scaler_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    bis_in_if.sink                           i_in,
    bis_out_if.source                        o_out,
    input  wire logic                        i_cfg_we,
    input  wire logic [bis_pkg::CFG_IW-1:0]  i_cfg_index,
    input  wire logic [bis_pkg::CFG_DW-1:0]  i_cfg_data
);
    import bis_pkg::*;

    // Configuration registers.
    logic              r_mode;
    logic [STEP_W-1:0] r_row_step;
    logic [STEP_W-1:0] r_col_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= 1'b0;
            r_row_step <= STEP_RESET;
            r_col_step <= STEP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MODE:     r_mode     <= i_cfg_data[0];
                CFG_ROW_STEP: r_row_step <= i_cfg_data[STEP_W-1:0];
                CFG_COL_STEP: r_col_step <= i_cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // The pipeline moves as one; it stalls only when a finished result waits.
    logic en;
    logic accept;
    logic r_o_vld;

    assign en          = !r_o_vld || o_out.ready;
    assign i_in.ready  = en;
    assign accept      = i_in.valid && en;

    // First stage: item capture and coordinate scaling.
    logic              r_a_vld;
    logic              r_a_wr;
    logic [ROW_AW-1:0] r_a_row;
    logic [COL_AW-1:0] r_a_col;
    logic [PIX_W-1:0]  r_a_pix;
    logic              in_store;

    // Writes outside the store are dropped here.
    assign in_store = (32'(i_in.row_index) < MAX_ROWS) && (32'(i_in.col_index) < MAX_COLS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_a_wr  <= 1'b0;
        end else if (en) begin
            r_a_vld <= accept && (i_in.operation == OP_COMPUTE);
            r_a_wr  <= accept && (i_in.operation == OP_WRITE) && in_store;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_row <= ROW_AW'(i_in.row_index);
            r_a_col <= COL_AW'(i_in.col_index);
            r_a_pix <= {i_in.pixel_c2, i_in.pixel_c1, i_in.pixel_c0};
        end
    end

    t_pos row_pos;
    t_pos col_pos;

    bis_pos u_row_pos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_idx   (i_in.row_index),
        .i_step  (r_row_step),
        .i_last  (IDX_AW'(MAX_ROWS - 1)),
        .o_pos   (row_pos)
    );

    bis_pos u_col_pos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_idx   (i_in.col_index),
        .i_step  (r_col_step),
        .i_last  (IDX_AW'(MAX_COLS - 1)),
        .o_pos   (col_pos)
    );

    // Second stage: frame store access. The store is split into four banks by
    // row and column parity, so the four neighbors sit in four different banks.
    // When a neighbor saturates onto its base, both come from the base's bank.
    logic [ROW_AW-1:0] r0, r1;
    logic [COL_AW-1:0] c0, c1;
    logic [PIX_W-1:0]  rd_data [4];

    assign r0 = row_pos.lo[ROW_AW-1:0];
    assign r1 = row_pos.hi[ROW_AW-1:0];
    assign c0 = col_pos.lo[COL_AW-1:0];
    assign c1 = col_pos.hi[COL_AW-1:0];

    for (genvar b = 0; b < 4; b++) begin : g_bank
        localparam logic RP = 1'((b >> 1) & 1);
        localparam logic CP = 1'(b & 1);
        logic [ROW_AW-1:0]  rd_row;
        logic [COL_AW-1:0]  rd_col;
        logic               we;

        assign rd_row = (r0[0] == RP) ? r0 : r1;
        assign rd_col = (c0[0] == CP) ? c0 : c1;
        assign we     = en && r_a_wr && (r_a_row[0] == RP) && (r_a_col[0] == CP);

        bis_bank u_bank (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_we    (we),
            .i_waddr ({r_a_row[ROW_AW-1:1], r_a_col[COL_AW-1:1]}),
            .i_wdata (r_a_pix),
            .i_raddr ({rd_row[ROW_AW-1:1], rd_col[COL_AW-1:1]}),
            .o_rdata (rd_data[b])
        );
    end

    logic                 r_b_vld;
    logic [FRAC_BITS-1:0] r_b_fr, r_b_fc;
    logic                 r_b_r0p, r_b_rsame, r_b_c0p, r_b_csame;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (en) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_fr    <= row_pos.frac;
            r_b_fc    <= col_pos.frac;
            r_b_r0p   <= r0[0];
            r_b_rsame <= (r0 == r1);
            r_b_c0p   <= c0[0];
            r_b_csame <= (c0 == c1);
        end
    end

    // Third stage: neighbor routing out of the banks and the four weights.
    logic              r1p, c1p;
    logic [WF_W-1:0]   inv_r, inv_c, fr_x, fc_x;
    logic [2*WF_W-1:0] m00, m10, m01, m11;
    logic              r_c_vld;
    t_weights          r_c_w;
    logic [PIX_W-1:0]  r_c_p00, r_c_p10, r_c_p01, r_c_p11;

    always_comb begin
        r1p   = r_b_rsame ? r_b_r0p : !r_b_r0p;
        c1p   = r_b_csame ? r_b_c0p : !r_b_c0p;
        fr_x  = WF_W'(r_b_fr);
        fc_x  = WF_W'(r_b_fc);
        inv_r = WF_W'(1 << FRAC_BITS) - fr_x;
        inv_c = WF_W'(1 << FRAC_BITS) - fc_x;
        m00   = (2*WF_W)'(inv_r) * (2*WF_W)'(inv_c);
        m10   = (2*WF_W)'(fr_x)  * (2*WF_W)'(inv_c);
        m01   = (2*WF_W)'(inv_r) * (2*WF_W)'(fc_x);
        m11   = (2*WF_W)'(fr_x)  * (2*WF_W)'(fc_x);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (en) begin
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_w.w00 <= W_W'(m00);
            r_c_w.w10 <= W_W'(m10);
            r_c_w.w01 <= W_W'(m01);
            r_c_w.w11 <= W_W'(m11);
            r_c_p00   <= rd_data[{r_b_r0p, r_b_c0p}];
            r_c_p10   <= rd_data[{r1p, r_b_c0p}];
            r_c_p01   <= rd_data[{r_b_r0p, c1p}];
            r_c_p11   <= rd_data[{r1p, c1p}];
        end
    end

    // Fourth and fifth stages: one lane per channel forms the weighted sum.
    logic [CH_W-1:0] lane_value [NUM_CH];

    for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_lane
        t_quad quad;

        assign quad.p00 = r_c_p00[ch*CH_W +: CH_W];
        assign quad.p10 = r_c_p10[ch*CH_W +: CH_W];
        assign quad.p01 = r_c_p01[ch*CH_W +: CH_W];
        assign quad.p11 = r_c_p11[ch*CH_W +: CH_W];

        bis_lane u_lane (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_pix   (quad),
            .i_w     (r_c_w),
            .o_value (lane_value[ch])
        );
    end

    logic r_d_vld, r_e_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
        end else if (en) begin
            r_d_vld <= r_c_vld;
            r_e_vld <= r_d_vld;
        end
    end

    // Merge stage: collect the lanes into the output register; grey mode
    // forces channels one and two to zero.
    logic [CH_W-1:0] r_res_c0, r_res_c1, r_res_c2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (en) begin
            r_o_vld <= r_e_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_res_c0 <= lane_value[0];
            r_res_c1 <= r_mode ? lane_value[1] : '0;
            r_res_c2 <= r_mode ? lane_value[2] : '0;
        end
    end

    assign o_out.valid     = r_o_vld;
    assign o_out.result_c0 = r_res_c0;
    assign o_out.result_c1 = r_res_c1;
    assign o_out.result_c2 = r_res_c2;

    a_grey_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !r_mode) |-> (o_out.result_c1 == '0 && o_out.result_c2 == '0))
        else $error("grey mode result carries color channels");
    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_a_wr) |=> !r_b_vld)
        else $error("write item entered the compute path");
    a_compute_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_c_vld) |=> r_d_vld)
        else $error("compute item lost between weight and lane stages");
    a_stage_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_a_vld && r_a_wr))
        else $error("first stage holds a write and a compute at once");

endmodule
`default_nettype wire
